@@ hdl/eif_pkg.sv @@
// types, constants and fixed-point helpers shared by the inviscid flux unit
`timescale 1ns / 1ps

package eif_pkg;

    localparam int Q_FRAC      = 16;
    localparam int GAMMA_W     = 18;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd26214;
    localparam int DIV_Q_W     = 48;   // quotient bits of (|mom| << 16) / rho
    localparam int WIDE_W      = 68;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_RHO = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    typedef struct packed {
        logic signed [31:0] density;
        logic signed [31:0] momentum_x;
        logic signed [31:0] momentum_y;
        logic signed [31:0] total_energy;
    } in_t;

    typedef struct packed {
        logic signed [31:0] fx_mass;
        logic signed [31:0] fx_mom_x;
        logic signed [31:0] fx_mom_y;
        logic signed [31:0] fx_energy;
        logic signed [31:0] fy_mass;
        logic signed [31:0] fy_mom_x;
        logic signed [31:0] fy_mom_y;
        logic signed [31:0] fy_energy;
        logic [1:0]         status;
    } out_t;

    // side data that rides along the velocity divider
    typedef struct packed {
        logic signed [31:0] mom_x;
        logic signed [31:0] mom_y;
        logic signed [31:0] energy;
        logic               bad_rho;
    } tag_t;

    // a * 2^-16, truncated toward zero
    function automatic logic signed [WIDE_W-1:0] q_shift(input logic signed [WIDE_W-1:0] a);
        logic signed [WIDE_W-1:0] adj;
        adj = a[WIDE_W-1] ? (a + 68'sd65535) : a;
        return adj >>> Q_FRAC;
    endfunction

    function automatic logic ovf32(input logic signed [WIDE_W-1:0] v);
        return (v > 68'sd2147483647) || (v < -68'sd2147483648);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -68'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ hdl/eif_vel_div.sv @@
// pipelined restoring divider: both velocities from the momenta over density
`timescale 1ns / 1ps

module eif_vel_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] den,
    input  eif_pkg::tag_t      tag_in,
    output logic               out_valid,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic               vel_sat,
    output eif_pkg::tag_t      tag_out
);
    import eif_pkg::*;

    localparam int NQ = DIV_Q_W;

    logic              v_reg   [0:NQ];
    logic [NQ-1:0]     shx_reg [0:NQ];
    logic [NQ-1:0]     shy_reg [0:NQ];
    logic [31:0]       remx_reg[0:NQ];
    logic [31:0]       remy_reg[0:NQ];
    logic [30:0]       den_reg [0:NQ];
    tag_t              tag_reg [0:NQ];

    logic [31:0] mag_x, mag_y;
    assign mag_x = tag_in.mom_x[31] ? (32'd0 - tag_in.mom_x) : tag_in.mom_x;
    assign mag_y = tag_in.mom_y[31] ? (32'd0 - tag_in.mom_y) : tag_in.mom_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            shx_reg[0]  <= {mag_x, 16'd0};
            shy_reg[0]  <= {mag_y, 16'd0};
            remx_reg[0] <= '0;
            remy_reg[0] <= '0;
            den_reg[0]  <= den[30:0];
            tag_reg[0]  <= tag_in;
        end
    end

    // one quotient bit per stage, msb first; the dividend shifts out as the quotient shifts in
    for (genvar i = 0; i < NQ; i++)
    begin : g_step
        logic [32:0] trial_x, trial_y;
        logic        ge_x, ge_y;
        logic [32:0] diff_x, diff_y;

        always_comb
        begin
            trial_x = {remx_reg[i], shx_reg[i][NQ-1]};
            trial_y = {remy_reg[i], shy_reg[i][NQ-1]};
            ge_x    = trial_x >= {2'b00, den_reg[i]};
            ge_y    = trial_y >= {2'b00, den_reg[i]};
            diff_x  = trial_x - {2'b00, den_reg[i]};
            diff_y  = trial_y - {2'b00, den_reg[i]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                remx_reg[i+1] <= ge_x ? diff_x[31:0] : trial_x[31:0];
                remy_reg[i+1] <= ge_y ? diff_y[31:0] : trial_y[31:0];
                shx_reg[i+1]  <= {shx_reg[i][NQ-2:0], ge_x};
                shy_reg[i+1]  <= {shy_reg[i][NQ-2:0], ge_y};
                den_reg[i+1]  <= den_reg[i];
                tag_reg[i+1]  <= tag_reg[i];
            end
        end
    end

    // sign and clamp to the Q16.16 range
    logic               ovx, ovy;
    logic signed [31:0] vx_next, vy_next;
    logic               out_valid_reg;
    logic signed [31:0] vel_x_reg, vel_y_reg;
    logic               vel_sat_reg;
    tag_t               tag_out_reg;

    always_comb
    begin
        if (tag_reg[NQ].mom_x[31])
        begin
            ovx     = shx_reg[NQ] > 48'd2147483648;
            vx_next = ovx ? 32'sh80000000 : (32'd0 - shx_reg[NQ][31:0]);
        end
        else
        begin
            ovx     = shx_reg[NQ] > 48'd2147483647;
            vx_next = ovx ? 32'sh7fffffff : shx_reg[NQ][31:0];
        end
        if (tag_reg[NQ].mom_y[31])
        begin
            ovy     = shy_reg[NQ] > 48'd2147483648;
            vy_next = ovy ? 32'sh80000000 : (32'd0 - shy_reg[NQ][31:0]);
        end
        else
        begin
            ovy     = shy_reg[NQ] > 48'd2147483647;
            vy_next = ovy ? 32'sh7fffffff : shy_reg[NQ][31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v_reg[NQ];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vel_x_reg   <= vx_next;
            vel_y_reg   <= vy_next;
            vel_sat_reg <= ovx | ovy;
            tag_out_reg <= tag_reg[NQ];
        end
    end

    assign out_valid = out_valid_reg;
    assign vel_x     = vel_x_reg;
    assign vel_y     = vel_y_reg;
    assign vel_sat   = vel_sat_reg;
    assign tag_out   = tag_out_reg;

endmodule

@@ hdl/euler_inviscid_flux_2d_unit.sv @@
// top level of the 2d inviscid euler flux unit
`timescale 1ns / 1ps

// Usage:
//   in channel: in_valid / in_stall / in_data carry one conserved state
//   (density, momenta, total energy, signed Q16.16) per request.
//   out channel: out_valid / out_stall / out_data carry both flux vectors
//   and a status code (ok, density not positive, a result saturated).
//   cfg_we / cfg_data write gamma - 1 (unsigned Q2.16), only while idle.
//   Throughput: one request per cycle while no result is stalled.
//   The velocity divider resolves its 48 quotient bits one per stage and
//   then clamps; the seven multiply, pressure and flux stages follow.
//   Reset clears every valid bit and loads gamma - 1 with 0.4.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   in_stall rises in the same cycle; bubbles inside the pipeline hold as
//   well, so nothing is lost or repeated.
module euler_inviscid_flux_2d_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  eif_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output eif_pkg::out_t                  out_data,
    input  logic                           cfg_we,
    input  logic [eif_pkg::GAMMA_W-1:0]    cfg_data
);
    import eif_pkg::*;

    logic               adv;
    logic [GAMMA_W-1:0] gamma_reg;
    logic               out_valid_reg;
    out_t               out_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= GAMMA_RESET;
        end
        else if (cfg_we)
        begin
            gamma_reg <= cfg_data;
        end
    end

    // velocities
    tag_t               tag_in;
    logic               d_valid;
    logic signed [31:0] d_vx, d_vy;
    logic               d_vsat;
    tag_t               d_tag;

    always_comb
    begin
        tag_in.mom_x   = in_data.momentum_x;
        tag_in.mom_y   = in_data.momentum_y;
        tag_in.energy  = in_data.total_energy;
        tag_in.bad_rho = (in_data.density <= 32'sd0);
    end

    eif_vel_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_valid),
        .den       (in_data.density),
        .tag_in    (tag_in),
        .out_valid (d_valid),
        .vel_x     (d_vx),
        .vel_y     (d_vy),
        .vel_sat   (d_vsat),
        .tag_out   (d_tag)
    );

    // carried through the arithmetic stages
    typedef struct packed {
        tag_t               tag;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               vsat;
    } carry_t;

    carry_t d_carry;
    always_comb
    begin
        d_carry.tag  = d_tag;
        d_carry.vx   = d_vx;
        d_carry.vy   = d_vy;
        d_carry.vsat = d_vsat;
    end

    logic   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    carry_t c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    // stage 1: momentum times velocity products
    logic signed [63:0] pxx_reg, pyy_reg, pxy_reg, pyx_reg;
    // stage 2: scaled products and kinetic energy
    logic signed [47:0] txx_reg, tyy_reg, txy_reg, tyx_reg, ke_reg;
    logic signed [47:0] txx_next, tyy_next, txy_next, tyx_next, ke_next;
    logic signed [WIDE_W-1:0] sh_xx, sh_yy, sh_xy, sh_yx;
    logic signed [48:0] kes, kes_adj;
    // stage 3: (energy - ke) * (gamma - 1)
    logic signed [48:0] inner;
    logic signed [WIDE_W-1:0] ig_reg, ig_next;
    logic signed [47:0] txy3_reg, tyx3_reg, txx3_reg, tyy3_reg;
    // stage 4: pressure, diagonal terms, clamped energy plus pressure
    logic signed [WIDE_W-1:0] pres_w;
    logic signed [52:0] pres, hs, fmxx_next, fmyy_next;
    logic signed [52:0] fmxx_reg, fmyy_reg;
    logic signed [48:0] hsum_reg, hsum_next;
    logic               hflag_reg, hflag_next;
    logic signed [47:0] txy4_reg, tyx4_reg;
    // stage 5: split of energy plus pressure
    logic signed [WIDE_W-1:0] hq_w;
    logic signed [48:0] hrem;
    logic signed [32:0] hq_reg;
    logic signed [16:0] hr_reg;
    logic signed [52:0] fmxx5_reg, fmyy5_reg;
    logic signed [47:0] txy5_reg, tyx5_reg;
    logic               hflag5_reg;
    // stage 6: energy flux partial products
    logic signed [64:0] qvx_reg, qvy_reg;
    logic signed [48:0] rvx_reg, rvy_reg;
    logic signed [52:0] fmxx6_reg, fmyy6_reg;
    logic signed [47:0] txy6_reg, tyx6_reg;
    logic               hflag6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= d_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            out_valid_reg <= v6_reg;
        end
    end

    always_comb
    begin
        sh_xx    = q_shift(WIDE_W'(pxx_reg));
        sh_yy    = q_shift(WIDE_W'(pyy_reg));
        sh_xy    = q_shift(WIDE_W'(pxy_reg));
        sh_yx    = q_shift(WIDE_W'(pyx_reg));
        txx_next = sh_xx[47:0];
        tyy_next = sh_yy[47:0];
        txy_next = sh_xy[47:0];
        tyx_next = sh_yx[47:0];
        kes      = 49'(txx_next) + 49'(tyy_next);
        // halve toward zero
        kes_adj  = kes + $signed({48'd0, kes[48]});
        ke_next  = kes_adj[48:1];

        inner    = 49'(c2_reg.tag.energy) - 49'(ke_reg);
        ig_next  = WIDE_W'(inner) * WIDE_W'($signed({1'b0, gamma_reg}));

        pres_w    = q_shift(ig_reg);
        pres      = pres_w[52:0];
        hs        = 53'(c3_reg.tag.energy) + pres;
        fmxx_next = 53'(txx3_reg) + pres;
        fmyy_next = 53'(tyy3_reg) + pres;
        // clamp energy plus pressure to +-2^47
        if (hs > 53'sd140737488355328)
        begin
            hsum_next  = 49'sd140737488355328;
            hflag_next = (c3_reg.vx != 32'sd0) || (c3_reg.vy != 32'sd0);
        end
        else if (hs < -53'sd140737488355328)
        begin
            hsum_next  = -49'sd140737488355328;
            hflag_next = (c3_reg.vx != 32'sd0) || (c3_reg.vy != 32'sd0);
        end
        else
        begin
            hsum_next  = hs[48:0];
            hflag_next = 1'b0;
        end

        hq_w = q_shift(WIDE_W'(hsum_reg));
        hrem = hsum_reg - $signed({hq_w[32:0], 16'd0});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg  <= d_carry;
            pxx_reg <= 64'(d_tag.mom_x) * 64'(d_vx);
            pyy_reg <= 64'(d_tag.mom_y) * 64'(d_vy);
            pxy_reg <= 64'(d_tag.mom_x) * 64'(d_vy);
            pyx_reg <= 64'(d_tag.mom_y) * 64'(d_vx);

            c2_reg  <= c1_reg;
            txx_reg <= txx_next;
            tyy_reg <= tyy_next;
            txy_reg <= txy_next;
            tyx_reg <= tyx_next;
            ke_reg  <= ke_next;

            c3_reg   <= c2_reg;
            ig_reg   <= ig_next;
            txx3_reg <= txx_reg;
            tyy3_reg <= tyy_reg;
            txy3_reg <= txy_reg;
            tyx3_reg <= tyx_reg;

            c4_reg    <= c3_reg;
            fmxx_reg  <= fmxx_next;
            fmyy_reg  <= fmyy_next;
            hsum_reg  <= hsum_next;
            hflag_reg <= hflag_next;
            txy4_reg  <= txy3_reg;
            tyx4_reg  <= tyx3_reg;

            c5_reg     <= c4_reg;
            hq_reg     <= hq_w[32:0];
            hr_reg     <= hrem[16:0];
            fmxx5_reg  <= fmxx_reg;
            fmyy5_reg  <= fmyy_reg;
            txy5_reg   <= txy4_reg;
            tyx5_reg   <= tyx4_reg;
            hflag5_reg <= hflag_reg;

            c6_reg     <= c5_reg;
            qvx_reg    <= 65'(hq_reg) * 65'(c5_reg.vx);
            qvy_reg    <= 65'(hq_reg) * 65'(c5_reg.vy);
            rvx_reg    <= 49'(hr_reg) * 49'(c5_reg.vx);
            rvy_reg    <= 49'(hr_reg) * 49'(c5_reg.vy);
            fmxx6_reg  <= fmxx5_reg;
            fmyy6_reg  <= fmyy5_reg;
            txy6_reg   <= txy5_reg;
            tyx6_reg   <= tyx5_reg;
            hflag6_reg <= hflag5_reg;
        end
    end

    // stage 7: energy flux, output clamp and status
    logic signed [WIDE_W-1:0] ex, ey, w_mxx, w_mxy, w_myx, w_myy;
    logic                     any_ovf;
    out_t                     out_next;

    always_comb
    begin
        ex    = WIDE_W'(qvx_reg) + q_shift(WIDE_W'(rvx_reg));
        ey    = WIDE_W'(qvy_reg) + q_shift(WIDE_W'(rvy_reg));
        w_mxx = WIDE_W'(fmxx6_reg);
        w_mxy = WIDE_W'(txy6_reg);
        w_myx = WIDE_W'(tyx6_reg);
        w_myy = WIDE_W'(fmyy6_reg);
        any_ovf = ovf32(ex) | ovf32(ey) | ovf32(w_mxx) | ovf32(w_mxy)
                | ovf32(w_myx) | ovf32(w_myy);
        if (c6_reg.tag.bad_rho)
        begin
            out_next        = '0;
            out_next.status = ST_BAD_RHO;
        end
        else
        begin
            out_next.fx_mass   = c6_reg.tag.mom_x;
            out_next.fx_mom_x  = sat32(w_mxx);
            out_next.fx_mom_y  = sat32(w_mxy);
            out_next.fx_energy = sat32(ex);
            out_next.fy_mass   = c6_reg.tag.mom_y;
            out_next.fy_mom_x  = sat32(w_myx);
            out_next.fy_mom_y  = sat32(w_myy);
            out_next.fy_energy = sat32(ey);
            out_next.status    = (c6_reg.vsat | hflag6_reg | any_ovf) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a bad density gives an all-zero flux
    a_bad_rho_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_BAD_RHO |->
            out_data.fx_mass == 32'sd0 && out_data.fx_mom_x == 32'sd0 &&
            out_data.fx_energy == 32'sd0 && out_data.fy_mom_y == 32'sd0)
        else $error("nonzero flux with bad density");

    // no x momentum means no x velocity, so the cross and x energy terms vanish
    a_zero_mx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_OK && out_data.fx_mass == 32'sd0 |->
            out_data.fx_mom_y == 32'sd0 && out_data.fy_mom_x == 32'sd0 &&
            out_data.fx_energy == 32'sd0)
        else $error("x terms nonzero with zero x momentum");

    // the input side holds only while a result waits: it is free whenever the output drains
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |-> !in_stall)
        else $error("input stalled while output drains");

endmodule
